// ===== rtl/ema_normalize_deadzone_core_defines.svh =====
// Assertion helpers for the sensor conditioner.
// Each macro expects clk and rst_n in scope.
`ifndef EMA_NORMALIZE_DEADZONE_CORE_DEFINES_SVH
`define EMA_NORMALIZE_DEADZONE_CORE_DEFINES_SVH

// Same-cycle implication.
`define EMADZ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EMADZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/emadz_pkg.sv =====
package emadz_pkg;

  localparam int CH_COUNT     = 5;
  localparam int SAMPLE_BITS  = 12;
  localparam int SMOOTH_SHIFT = 3;

  localparam int CH_BITS      = 3;
  localparam int CH_IDX_BITS  = (CH_COUNT > 1) ? $clog2(CH_COUNT) : 1;
  localparam int CAL_BITS     = 12;
  localparam int CAL_REG_BITS = 60;
  localparam int PCT_BITS     = 7;
  localparam int FULL_SCALE   = 100;
  localparam int CFG_IDX_BITS = 2;

  localparam int CMP_W        = (SAMPLE_BITS > CAL_BITS) ? SAMPLE_BITS : CAL_BITS;
  localparam int NUM_W        = CMP_W + PCT_BITS;
  localparam int ACC_W        = SAMPLE_BITS + SMOOTH_SHIFT + 1;
  localparam int DIV_STEPS    = PCT_BITS;
  localparam int CNT_BITS     = $clog2(DIV_STEPS);
  localparam int ENTRY_W      = SAMPLE_BITS + PCT_BITS;

  localparam logic [CAL_REG_BITS-1:0] CAL_LOW_RESET  = 60'd337852455562446000;
  localparam logic [CAL_REG_BITS-1:0] CAL_HIGH_RESET = 60'd900939881499856000;
  localparam logic [PCT_BITS-1:0]     DEADZONE_RESET = 7'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CAL_LOWS  = 2'd0,
    CFG_CAL_HIGHS = 2'd1,
    CFG_DEADZONE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCALE,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== rtl/ema_normalize_deadzone_core.sv =====
// Five-channel sensor conditioner: per-channel smoothing, calibration scaling
// to 0..100 percent and a deadband on the held output.
// Input channel (in_valid/in_ready): channel index and 12-bit sample.
// Result channel (out_valid/out_ready): channel echoed and its held percent.
// Config port: cfg_wr_en writes cfg_wdata into register cfg_index at once
// (0 calibration lows, 1 calibration highs, 2 deadzone); other indexes are
// ignored. Write only while the block is idle.
// One item is worked on at a time. Per-channel state sits in a 5-entry
// synchronous RAM (registered read). From acceptance to the result register
// an item whose level lies strictly between the channel limits passes
// through: accept, RAM read, scale setup, 7 restoring-division steps (one
// quotient bit each), write-back. Clamped levels skip the divider;
// out-of-range channels also skip the scale setup.
// The next item is accepted in the cycle after the result is loaded, even
// while that result waits at the output.
// When the receiver stalls with a result pending, the block holds in its
// write-back step until the output register frees up.
// Reset (synchronous, active low) restores the calibration defaults, a
// deadzone of 2 and clears every channel's level and held output by
// clearing the per-entry valid bits; no clearing pass is needed.
`include "ema_normalize_deadzone_core_defines.svh"

module ema_normalize_deadzone_core
  import emadz_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CH_BITS-1:0]      in_channel_index,
  input  logic [SAMPLE_BITS-1:0]  in_raw_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CH_BITS-1:0]      out_result_channel,
  output logic [PCT_BITS-1:0]     out_held_level,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CAL_REG_BITS-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CAL_REG_BITS-1:0] cal_lows_r;
  logic [CAL_REG_BITS-1:0] cal_highs_r;
  logic [PCT_BITS-1:0]     deadzone_r;

  logic [ENTRY_W-1:0] mem [CH_COUNT];
  logic [ENTRY_W-1:0] mem_q_r;
  logic [CH_COUNT-1:0] vld_r;

  logic [CH_BITS-1:0]     ch_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] level_r;
  logic [PCT_BITS-1:0]    held_old_r;
  logic [PCT_BITS-1:0]    pct_r;
  logic [NUM_W-1:0]       num_r;
  logic [CMP_W-1:0]       den_r;
  logic [CNT_BITS-1:0]    cnt_r;

  logic                   out_valid_r;
  logic [CH_BITS-1:0]     out_result_channel_r;
  logic [PCT_BITS-1:0]    out_held_level_r;

  logic in_accept;
  logic rd_en;
  logic mem_we;
  logic out_load;
  logic ch_in_range;
  logic in_ch_ok;

  logic [CH_IDX_BITS-1:0] ch_idx;
  logic [CH_IDX_BITS-1:0] in_idx;

  logic [CAL_BITS-1:0]    cal_lo_a [CH_COUNT];
  logic [CAL_BITS-1:0]    cal_hi_a [CH_COUNT];
  logic [CMP_W-1:0]       lvl_c, lo_c, hi_c, diff_lvl;
  logic                   at_low, at_high;

  logic [ENTRY_W-1:0]     entry_old;
  logic [SAMPLE_BITS-1:0] base_lvl;
  logic [ACC_W-1:0]       acc;
  logic [NUM_W-1:0]       trial;
  logic [PCT_BITS-1:0]    pct_diff;
  logic [PCT_BITS-1:0]    held_new;

  assign ch_idx      = ch_r[CH_IDX_BITS-1:0];
  assign in_idx      = in_channel_index[CH_IDX_BITS-1:0];
  assign ch_in_range = (ch_r < CH_BITS'(CH_COUNT));
  assign in_ch_ok    = (in_channel_index < CH_BITS'(CH_COUNT));

  // Unpack per-channel calibration limits.
  always_comb begin
    for (int k = 0; k < CH_COUNT; k++) begin
      cal_lo_a[k] = cal_lows_r[k*CAL_BITS +: CAL_BITS];
      cal_hi_a[k] = cal_highs_r[k*CAL_BITS +: CAL_BITS];
    end
  end

  // Smoothing: an unseeded channel starts from the sample itself.
  always_comb begin
    entry_old = vld_r[ch_idx] ? mem_q_r : '0;
    base_lvl  = (entry_old[ENTRY_W-1 -: SAMPLE_BITS] == '0) ? sample_r
                                                            : entry_old[ENTRY_W-1 -: SAMPLE_BITS];
    acc = (ACC_W'(base_lvl) << SMOOTH_SHIFT) - ACC_W'(base_lvl) + ACC_W'(sample_r);
  end

  // Scale setup compares.
  always_comb begin
    lvl_c    = CMP_W'(level_r);
    lo_c     = ch_in_range ? CMP_W'(cal_lo_a[ch_idx]) : '0;
    hi_c     = ch_in_range ? CMP_W'(cal_hi_a[ch_idx]) : '0;
    at_low   = (lvl_c <= lo_c);
    at_high  = (lvl_c >= hi_c);
    diff_lvl = lvl_c - lo_c;
  end

  assign trial = NUM_W'(den_r) << cnt_r;

  // Deadband against the held output.
  always_comb begin
    pct_diff = (pct_r >= held_old_r) ? (pct_r - held_old_r) : (held_old_r - pct_r);
    if (!ch_in_range) begin
      held_new = '0;
    end else if (pct_diff >= deadzone_r) begin
      held_new = pct_r;
    end else begin
      held_new = held_old_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = ch_in_range ? S_SCALE : S_DONE;
      end
      S_SCALE: begin
        state_nxt = (at_low || at_high) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (cnt_r == '0) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    mem_we   = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_DONE: begin
        out_load = !out_valid_r || out_ready;
        mem_we   = out_load && ch_in_range;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_accept = in_valid && in_ready;
  assign rd_en     = in_accept && in_ch_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_lows_r  <= CAL_LOW_RESET;
      cal_highs_r <= CAL_HIGH_RESET;
      deadzone_r  <= DEADZONE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CAL_LOWS:  cal_lows_r  <= cfg_wdata;
        CFG_CAL_HIGHS: cal_highs_r <= cfg_wdata;
        CFG_DEADZONE:  deadzone_r  <= cfg_wdata[PCT_BITS-1:0];
        default: begin
          deadzone_r <= deadzone_r;
        end
      endcase
    end
  end

  // Channel state RAM: level in the upper bits, held percent below.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[in_idx];
    end
    if (mem_we) begin
      mem[ch_idx] <= {level_r, held_new};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[ch_idx] <= 1'b1;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch_r     <= in_channel_index;
      sample_r <= in_raw_sample;
    end
    case (state_r)
      S_READ: begin
        level_r    <= acc[SMOOTH_SHIFT +: SAMPLE_BITS];
        held_old_r <= entry_old[PCT_BITS-1:0];
      end
      S_SCALE: begin
        // x*100 = x*64 + x*32 + x*4
        num_r <= (NUM_W'(diff_lvl) << 6) + (NUM_W'(diff_lvl) << 5) + (NUM_W'(diff_lvl) << 2);
        den_r <= hi_c - lo_c;
        cnt_r <= CNT_BITS'(DIV_STEPS - 1);
        if (at_low) begin
          pct_r <= '0;
        end else if (at_high) begin
          pct_r <= PCT_BITS'(FULL_SCALE);
        end else begin
          pct_r <= '0;
        end
      end
      S_DIV: begin
        if (num_r >= trial) begin
          num_r        <= num_r - trial;
          pct_r[cnt_r] <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_channel_r <= ch_r;
      out_held_level_r     <= held_new;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_channel = out_result_channel_r;
  assign out_held_level     = out_held_level_r;

  `EMADZ_ASSERT_SAME(a_oor_zero, out_valid_r && (out_result_channel_r >= CH_BITS'(CH_COUNT)), out_held_level_r == '0, "out-of-range channel gave nonzero level")
  `EMADZ_ASSERT_SAME(a_held_range, out_valid_r, out_held_level_r <= PCT_BITS'(FULL_SCALE), "held level above full scale")
  `EMADZ_ASSERT_SAME(a_we_in_range, mem_we, ch_in_range, "state write for out-of-range channel")
  `EMADZ_ASSERT_NEXT(a_out_load, out_load, out_valid_r && (out_result_channel_r == $past(ch_r)), "result not loaded for current item")

endmodule

// ===== tb/ema_normalize_deadzone_checker.sv =====
module ema_normalize_deadzone_checker
  import emadz_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [CH_BITS-1:0]      in_channel_index,
  input  logic [SAMPLE_BITS-1:0]  in_raw_sample,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [CH_BITS-1:0]      out_result_channel,
  input  logic [PCT_BITS-1:0]     out_held_level,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CAL_REG_BITS-1:0] cfg_wdata,
  output int                      fail_count,
  output int                      expected_count
);

  typedef struct packed {
    logic [CH_BITS-1:0]  chan;
    logic [PCT_BITS-1:0] held;
  } held_result_t;

  logic [CAL_REG_BITS-1:0] cal_lows;
  logic [CAL_REG_BITS-1:0] cal_highs;
  logic [PCT_BITS-1:0]     dead_zone;
  logic [SAMPLE_BITS-1:0]  smooth_lvl [CH_COUNT];
  logic [PCT_BITS-1:0]     held_pct [CH_COUNT];

  held_result_t pending_levels[$];

  function automatic held_result_t advance_channel(input logic [CH_BITS-1:0] ch,
                                                   input logic [SAMPLE_BITS-1:0] smp);
    held_result_t r;
    logic [SAMPLE_BITS-1:0] lvl;
    logic [CAL_BITS-1:0] lo, hi;
    int acc, pct, diff;
    r.chan = ch;
    r.held = '0;
    if (ch >= CH_COUNT) return r;
    lvl = smooth_lvl[ch];
    // an unseeded channel starts from the sample itself
    if (lvl == '0) lvl = smp;
    acc = int'(lvl) * ((1 << SMOOTH_SHIFT) - 1) + int'(smp);
    lvl = SAMPLE_BITS'(acc >> SMOOTH_SHIFT);
    smooth_lvl[ch] = lvl;
    lo = cal_lows[ch*CAL_BITS +: CAL_BITS];
    hi = cal_highs[ch*CAL_BITS +: CAL_BITS];
    if (lvl <= lo) pct = 0;
    else if (lvl >= hi) pct = FULL_SCALE;
    else pct = ((int'(lvl) - int'(lo)) * FULL_SCALE) / (int'(hi) - int'(lo));
    diff = (pct >= int'(held_pct[ch])) ? pct - int'(held_pct[ch]) : int'(held_pct[ch]) - pct;
    if (diff >= int'(dead_zone)) held_pct[ch] = PCT_BITS'(pct);
    r.held = held_pct[ch];
    return r;
  endfunction

  always @(posedge clk) begin
    held_result_t want;
    if (!rst_n) begin
      fail_count = 0;
      cal_lows = CAL_LOW_RESET;
      cal_highs = CAL_HIGH_RESET;
      dead_zone = DEADZONE_RESET;
      for (int k = 0; k < CH_COUNT; k++) begin
        smooth_lvl[k] = '0;
        held_pct[k] = '0;
      end
      pending_levels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CAL_LOWS:  cal_lows = cfg_wdata;
          CFG_CAL_HIGHS: cal_highs = cfg_wdata;
          CFG_DEADZONE:  dead_zone = cfg_wdata[PCT_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_levels.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item channel %0d level %0d", $time,
                   out_result_channel, out_held_level);
        end else begin
          want = pending_levels.pop_front();
          if (out_result_channel !== want.chan) begin
            fail_count++;
            $display("%0t: result_channel expected %0d actual %0d", $time,
                     want.chan, out_result_channel);
          end
          if (out_held_level !== want.held) begin
            fail_count++;
            $display("%0t: held_level expected %0d actual %0d (channel %0d)", $time,
                     want.held, out_held_level, want.chan);
          end
        end
      end
      if (in_valid && in_ready)
        pending_levels.push_back(advance_channel(in_channel_index, in_raw_sample));
    end
    expected_count = pending_levels.size();
  end

endmodule

// ===== tb/tb_ema_normalize_deadzone_core.sv =====
module tb_ema_normalize_deadzone_core
  import emadz_pkg::*;
();

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS = 220;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [CH_BITS-1:0]      in_channel_index;
  logic [SAMPLE_BITS-1:0]  in_raw_sample;
  logic                    out_valid;
  logic                    out_ready;
  logic [CH_BITS-1:0]      out_result_channel;
  logic [PCT_BITS-1:0]     out_held_level;
  logic                    cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CAL_REG_BITS-1:0] cfg_wdata;

  int         fail_count;
  int         expected_count;
  idle_mode_t idle_mode;
  int         hold_requests = 0;
  int         quiet_cycles;

  ema_normalize_deadzone_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_channel_index(in_channel_index), .in_raw_sample(in_raw_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_channel(out_result_channel), .out_held_level(out_held_level),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ema_normalize_deadzone_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_channel_index(in_channel_index), .in_raw_sample(in_raw_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_channel(out_result_channel), .out_held_level(out_held_level),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .expected_count(expected_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 68;
      IDLE_BOTH:   return $urandom_range(0, 99) < 31;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 68;
      IDLE_BOTH:     return $urandom_range(0, 99) < 31;
      default:       return 1'b0;
    endcase
  endfunction

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    int hold_seen;
    int rx_hold_left;
    hold_seen = 0;
    rx_hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        rx_hold_left = HOLD_OFF_CYCLES;
      end
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= !receiver_stall();
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // returns at the falling edge after acceptance with valid still high
  task automatic send_item(input int ch, input int smp);
    while (sender_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_channel_index <= ch[CH_BITS-1:0];
    in_raw_sample <= smp[SAMPLE_BITS-1:0];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid, drain every outstanding item, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CAL_REG_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic pick_config();
    logic [CAL_REG_BITS-1:0] lows, highs;
    int lo, hi, k, dz;
    lows = '0;
    highs = '0;
    for (k = 0; k < CH_COUNT; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          lo = $urandom_range(0, 4095);
          hi = $urandom_range(0, 4095);
        end
        1: begin
          lo = $urandom_range(0, 4000);
          hi = lo + $urandom_range(1, 20);
        end
        default: begin
          lo = $urandom_range(0, 3000);
          hi = lo + $urandom_range(1, 4095 - lo);
        end
      endcase
      lows[k*CAL_BITS +: CAL_BITS] = lo[CAL_BITS-1:0];
      highs[k*CAL_BITS +: CAL_BITS] = hi[CAL_BITS-1:0];
    end
    case ($urandom_range(0, 3))
      0:       dz = 0;
      3:       dz = $urandom_range(0, 127);
      default: dz = $urandom_range(1, 10);
    endcase
    settle();
    write_reg(CFG_CAL_LOWS, lows);
    write_reg(CFG_CAL_HIGHS, highs);
    write_reg(CFG_DEADZONE, CAL_REG_BITS'(dz));
  endtask

  task automatic run_directed();
    // reset calibration: 1200..3200, deadzone 2
    send_item(0, 0);
    send_item(0, 0);
    send_item(0, 4095);
    send_item(0, 0);
    send_item(1, 2200);
    send_item(1, 2216);
    send_item(2, 1200);
    send_item(3, 3200);
    send_item(4, 1201);
    send_item(5, 4095);
    send_item(6, 0);
    send_item(7, 2048);
    // equal and inverted limits on channels 0 and 1, deadzone off
    settle();
    write_reg(CFG_CAL_LOWS,  {12'd100, 12'd4095, 12'd0, 12'd3000, 12'd2000});
    write_reg(CFG_CAL_HIGHS, {12'd4095, 12'd4095, 12'd4095, 12'd1000, 12'd2000});
    write_reg(CFG_DEADZONE, CAL_REG_BITS'(0));
    send_item(0, 1000);
    send_item(1, 4095);
    send_item(2, 2048);
    send_item(3, 4095);
    send_item(4, 4095);
    // deadzone beyond full scale freezes the held output
    settle();
    write_reg(CFG_DEADZONE, CAL_REG_BITS'(127));
    send_item(2, 0);
    send_item(4, 0);
    settle();
    write_reg(CFG_DEADZONE, CAL_REG_BITS'(100));
    send_item(2, 4095);
    settle();
    write_reg(CFG_SPARE, '1);
    write_reg(CFG_CAL_LOWS, '0);
    write_reg(CFG_CAL_HIGHS, '1);
    send_item(0, 4095);
    send_item(1, 1);
    settle();
    write_reg(CFG_DEADZONE, CAL_REG_BITS'(101));
    write_reg(CFG_CAL_LOWS, '1);
    write_reg(CFG_CAL_HIGHS, '0);
    send_item(3, 0);
  endtask

  initial begin
    idle_mode_t phase_modes[5];
    int smp, ch;
    phase_modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_RECEIVER};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_channel_index = '0;
    in_raw_sample = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_CAL_LOWS;
    cfg_wdata = '0;
    idle_mode = IDLE_NONE;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    for (int p = 0; p < 5; p++) begin
      pick_config();
      idle_mode = phase_modes[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off the receiver so the block backs up into the input
        if (p == 0 && i == 60) hold_requests++;
        if (p == 1 && i == 110) begin
          in_valid <= 1'b0;
          while (expected_count != 0) @(negedge clk);
        end
        ch = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        case ($urandom_range(0, 9))
          0:          smp = 0;
          1:          smp = 4095;
          2, 3, 4, 5: smp = $urandom_range(0, 4095);
          default:    smp = $urandom_range(1000, 3400);
        endcase
        send_item(ch, smp);
      end
    end

    idle_mode = IDLE_NONE;
    settle();
    if (fail_count == 0 && expected_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
